// ===== sv/clim_pkg.sv =====
// Shared types and constants for the client interval minimum table.
package clim_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // Command codes.
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_DEL    = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // One input word.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] client;
        logic        proc_flag;
        logic [31:0] interval;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_interval;
        logic [31:0] min_interval;
    } t_out_word;

    // One stored table entry.
    typedef struct packed {
        logic [15:0] client;
        logic        proc_flag;
        logic [31:0] interval;
    } t_entry;

    // Access request from the controller to the entry memory.
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } t_ram_req;

endpackage

// ===== sv/client_interval_min_table_core.sv =====
// Top level of the client interval minimum table: controller, entry memory and output register.
//
// Keeps up to TABLE_ENTRIES (16) interval requests keyed by client id and
// processor flag, and answers each command word with one result word that
// includes the smallest stored interval. Each word is handled one at a time:
// after acceptance the controller reads every entry once through the single
// read port of the entry memory, so a result is ready once the last entry
// has been read back, and the next word is taken in the
// cycle that result moves into the output register. A stalled output holds
// one finished result while the next word is already being scanned. Valid
// bits live in flip-flops and are cleared by reset, so no clearing pass is
// needed.
module client_interval_min_table_core import clim_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic      res_valid;
    t_out_word res_word;
    t_ram_req  ram_req;
    t_entry    rd_data;
    logic      out_free;

    logic      r_out_valid;
    t_out_word r_out_word;

    // The output register can take a word when empty or being drained.
    assign out_free = !r_out_valid || !i_out_stall;

    clim_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res_word  (res_word),
        .o_ram_req   (ram_req),
        .i_rd_data   (rd_data)
    );

    clim_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_out_word <= res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== sv/clim_ram.sv =====
// Entry memory: one write port and one registered read port.
module clim_ram import clim_pkg::*; (
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_entry   o_rd_data
);

    t_entry r_mem [0:TABLE_ENTRIES-1];
    t_entry r_rd_data;

    // Synchronous write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/clim_ctrl.sv =====
// Command sequencer: scans the entry memory, tracks key match, free slot and minimum.
module clim_ctrl import clim_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_free,
    output logic      o_res_valid,
    output t_out_word o_res_word,
    output t_ram_req  o_ram_req,
    input  t_entry    i_rd_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);

    t_state                   r_state;
    t_state                   n_state;
    t_in_word                 r_word;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_pend;
    logic [IDX_W-1:0]         r_pend_idx;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic                     r_hit;
    logic [IDX_W-1:0]         r_hit_idx;
    logic [31:0]              r_hit_ival;
    logic                     r_free_ok;
    logic [IDX_W-1:0]         r_free_idx;
    logic                     r_any;
    logic [31:0]              r_min;

    logic             accept;
    logic             commit;
    logic             rd_en;
    logic             e_valid;
    logic             e_match;
    logic             do_write;
    logic             do_clear;
    logic [IDX_W-1:0] wr_slot;
    logic [1:0]       res_status;
    logic [31:0]      res_found;
    logic [31:0]      res_min;

    // Smaller of a running minimum (if any) and a new value.
    function automatic logic [31:0] min_with(input logic any, input logic [31:0] cur,
                                             input logic [31:0] x);
        return (any && (cur < x)) ? cur : x;
    endfunction

    // Handshake: a new word enters when idle or when the previous result leaves.
    // Nothing is taken while reset is held.
    assign commit     = (r_state == S_FIN) && i_out_free;
    assign o_in_stall = !i_rst_n || !((r_state == S_IDLE) || commit);
    assign accept     = i_in_valid && !o_in_stall;

    // Scan reads one entry per cycle in address order.
    assign rd_en = (r_state == S_SCAN) && (r_cnt < CNT_END);

    // Classify the entry returned by the memory.
    assign e_valid = r_valid[r_pend_idx];
    assign e_match = e_valid && (i_rd_data.client == r_word.client)
                     && (i_rd_data.proc_flag == r_word.proc_flag);

    // Decide the action and the result once the scan is complete.
    always_comb begin
        do_write   = 1'b0;
        do_clear   = 1'b0;
        wr_slot    = r_hit ? r_hit_idx : r_free_idx;
        res_status = ST_OK;
        res_found  = 32'd0;
        res_min    = r_any ? r_min : 32'd0;
        case (r_word.cmd)
            CMD_ADD: begin
                if (r_hit || r_free_ok) begin
                    do_write = 1'b1;
                    res_min  = min_with(r_any, r_min, r_word.interval);
                end else begin
                    res_status = ST_FULL;
                end
            end
            CMD_DEL: begin
                if (r_hit) begin
                    do_clear = 1'b1;
                end else begin
                    res_status = ST_NOT_FOUND;
                end
            end
            CMD_LOOKUP: begin
                if (r_hit) begin
                    res_found = r_hit_ival;
                    res_min   = min_with(r_any, r_min, r_hit_ival);
                end else begin
                    res_status = ST_NOT_FOUND;
                end
            end
            default: begin
                // Unused command: table untouched, the matched entry still counts.
                if (r_hit) begin
                    res_min = min_with(r_any, r_min, r_hit_ival);
                end
            end
        endcase
    end

    // Memory requests.
    assign o_ram_req.wr_en   = commit && do_write;
    assign o_ram_req.wr_addr = wr_slot;
    assign o_ram_req.wr_data = '{client:    r_word.client,
                                 proc_flag: r_word.proc_flag,
                                 interval:  r_word.interval};
    assign o_ram_req.rd_en   = rd_en;
    assign o_ram_req.rd_addr = r_cnt[IDX_W-1:0];

    // Result toward the output register.
    assign o_res_valid = (r_state == S_FIN);
    assign o_res_word  = '{status: res_status, found_interval: res_found,
                           min_interval: res_min};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_pend && (r_pend_idx == LAST_IDX)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (accept) begin
                    n_state = S_SCAN;
                end else if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_cnt   <= '0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= rd_en;
            if (accept) begin
                r_cnt <= '0;
            end else if (rd_en) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (commit && do_write) begin
                r_valid[wr_slot] <= 1'b1;
            end
            if (commit && do_clear) begin
                r_valid[r_hit_idx] <= 1'b0;
            end
        end
    end

    // Word capture and scan trackers.
    always_ff @(posedge i_clk) begin
        r_pend_idx <= r_cnt[IDX_W-1:0];
        if (accept) begin
            r_word    <= i_in_word;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_any     <= 1'b0;
        end else if (r_pend) begin
            if (e_match) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_pend_idx;
                r_hit_ival <= i_rd_data.interval;
            end
            if (!e_valid && !r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_pend_idx;
            end
            if (e_valid && !e_match && (!r_any || (i_rd_data.interval < r_min))) begin
                r_any <= 1'b1;
                r_min <= i_rd_data.interval;
            end
        end
    end

`ifndef ASSERT_OFF
    // The memory is only written when a result is handed over.
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !o_ram_req.wr_en)
        else $error("entry memory written during scan");

    // An accepted word always starts a scan.
    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SCAN))
        else $error("accepted word did not start a scan");

    // A full status is only given when every slot is in use.
    a_full_really_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && (res_status == ST_FULL)) |-> (&r_valid))
        else $error("full reported with a free slot");

    // A matched slot is a valid slot at the end of the scan.
    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && r_hit) |-> r_valid[r_hit_idx])
        else $error("key match on an invalid slot");
`endif

endmodule

// ===== tb/tb_client_interval_min_table_core.sv =====
// Testbench for the client interval minimum table: directed rows, then phased random traffic.
module tb_client_interval_min_table_core;
    import clim_pkg::*;

    // Command code 3 is unused by the block and must be ignored.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam int RAND_ITEMS  = 1425;
    localparam int PHASE_LEN   = 150;
    localparam int QUIET_TAIL  = 200;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 500000;
    localparam int POOL_MAX    = 40;
    localparam int PRINT_MAX   = 50;

    // One row of the directed stimulus table.
    typedef struct {
        t_in_word  word;
        bit        known;
        t_out_word result;
    } t_stim_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    // Shadow copy of the request table.
    bit          tab_used [TABLE_ENTRIES];
    logic [15:0] tab_client [TABLE_ENTRIES];
    logic        tab_proc [TABLE_ENTRIES];
    logic [31:0] tab_ival [TABLE_ENTRIES];

    t_stim_row   directed_rows[$];
    t_out_word   results_due[$];
    t_out_word   due_word;
    logic [15:0] pool_id [POOL_MAX];
    logic        pool_proc [POOL_MAX];
    logic        idling      = 1'b1;
    int          stall_left  = 0;
    int          fail_count  = 0;
    int          result_count = 0;
    int          cycle_count = 0;

    client_interval_min_table_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    // Clock generation.
    initial begin
        forever #4 clk = ~clk;
    end

    // Cycle counter for the run limit.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Apply one command word to the shadow table and return the expected result word.
    function automatic t_out_word apply_command(input t_in_word w);
        t_out_word res;
        int        hit;
        int        spot;
        int        i;
        bit        any;
        res = '0;
        res.status = ST_OK;
        hit = -1;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            if (hit < 0 && tab_used[i] && tab_client[i] == w.client
                    && tab_proc[i] == w.proc_flag)
                hit = i;
        end
        case (w.cmd)
            CMD_ADD: begin
                // An existing key is overwritten; a new key takes the lowest free slot.
                spot = hit;
                for (i = 0; i < TABLE_ENTRIES; i++) begin
                    if (spot < 0 && !tab_used[i])
                        spot = i;
                end
                if (spot >= 0) begin
                    tab_used[spot]   = 1'b1;
                    tab_client[spot] = w.client;
                    tab_proc[spot]   = w.proc_flag;
                    tab_ival[spot]   = w.interval;
                end else begin
                    res.status = ST_FULL;
                end
            end
            CMD_DEL: begin
                if (hit >= 0)
                    tab_used[hit] = 1'b0;
                else
                    res.status = ST_NOT_FOUND;
            end
            CMD_LOOKUP: begin
                if (hit >= 0)
                    res.found_interval = tab_ival[hit];
                else
                    res.status = ST_NOT_FOUND;
            end
            default: begin
            end
        endcase
        // Smallest interval over the valid entries, zero when the table is empty.
        any = 1'b0;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            if (tab_used[i] && (!any || tab_ival[i] < res.min_interval)) begin
                res.min_interval = tab_ival[i];
                any = 1'b1;
            end
        end
        return res;
    endfunction

    // Print one mismatch line (up to a cap) and count it.
    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_MAX)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Directed row whose result is written out in the table.
    task automatic row_known(input logic [1:0] cmd, input logic [15:0] id, input logic proc,
                             input logic [31:0] ival, input logic [1:0] st,
                             input logic [31:0] found, input logic [31:0] least);
        t_stim_row r;
        r.word   = '{cmd: cmd, client: id, proc_flag: proc, interval: ival};
        r.known  = 1'b1;
        r.result = '{status: st, found_interval: found, min_interval: least};
        directed_rows.insert(directed_rows.size(), r);
    endtask

    // Directed row whose result comes from the shadow table.
    task automatic row_pred(input logic [1:0] cmd, input logic [15:0] id, input logic proc,
                            input logic [31:0] ival);
        t_stim_row r;
        r.word   = '{cmd: cmd, client: id, proc_flag: proc, interval: ival};
        r.known  = 1'b0;
        r.result = '0;
        directed_rows.insert(directed_rows.size(), r);
    endtask

    // Offer one word, wait until it is taken, then queue its expected result.
    task automatic send_word(input t_in_word w, input bit known, input t_out_word result);
        t_out_word predicted;
        int        gap;
        if (idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = apply_command(w);
        results_due.insert(results_due.size(), known ? result : predicted);
    endtask

    // Output stall in random bursts while idling is enabled.
    always @(posedge clk) begin
        if (!rst_n || !idling) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result word %h", out_word));
            end else begin
                due_word = results_due.pop_front();
                if (out_word.status !== due_word.status)
                    report_mismatch($sformatf("result %0d status %0d, expected %0d",
                        result_count, out_word.status, due_word.status));
                if (out_word.found_interval !== due_word.found_interval)
                    report_mismatch($sformatf("result %0d found_interval %h, expected %h",
                        result_count, out_word.found_interval, due_word.found_interval));
                if (out_word.min_interval !== due_word.min_interval)
                    report_mismatch($sformatf("result %0d min_interval %h, expected %h",
                        result_count, out_word.min_interval, due_word.min_interval));
            end
            result_count++;
        end
    end

    // Run limit.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    // Main stimulus.
    initial begin
        t_in_word w;
        int       n;
        int       k;
        int       r;
        int       pool_n;
        int       add_pct;

        for (k = 0; k < TABLE_ENTRIES; k++)
            tab_used[k] = 1'b0;
        pool_n  = 1;
        add_pct = 50;

        // Empty table, unused code, extremes of key and interval, zero interval.
        row_known(CMD_LOOKUP, 16'h0000, 1'b0, 32'h0000_0000, ST_NOT_FOUND, 32'h0, 32'h0);
        row_known(CMD_DEL,    16'hFFFF, 1'b1, 32'hFFFF_FFFF, ST_NOT_FOUND, 32'h0, 32'h0);
        row_known(CMD_SPARE,  16'h1234, 1'b1, 32'hFFFF_FFFF, ST_OK, 32'h0, 32'h0);
        row_known(CMD_ADD,    16'h0000, 1'b0, 32'hFFFF_FFFF, ST_OK, 32'h0, 32'hFFFF_FFFF);
        row_known(CMD_ADD,    16'hFFFF, 1'b1, 32'h0000_0000, ST_OK, 32'h0, 32'h0);
        row_known(CMD_LOOKUP, 16'hFFFF, 1'b1, 32'h5A5A_5A5A, ST_OK, 32'h0, 32'h0);
        row_known(CMD_LOOKUP, 16'h0000, 1'b0, 32'h0000_0000, ST_OK, 32'hFFFF_FFFF, 32'h0);
        row_known(CMD_DEL,    16'h0000, 1'b0, 32'h0000_0000, ST_OK, 32'h0, 32'h0);
        // Fill the table; the first row shares the id of a stored key with the other flag.
        row_pred(CMD_ADD, 16'hFFFF, 1'b0, 32'h0000_0007);
        row_pred(CMD_ADD, 16'h0001, 1'b0, 32'h8000_0000);
        row_pred(CMD_ADD, 16'h0002, 1'b1, 32'h0000_0001);
        row_pred(CMD_ADD, 16'h0004, 1'b0, 32'hAAAA_AAAA);
        row_pred(CMD_ADD, 16'h0008, 1'b1, 32'h5555_5555);
        row_pred(CMD_ADD, 16'h0010, 1'b0, 32'h0001_0000);
        row_pred(CMD_ADD, 16'h0020, 1'b1, 32'h7FFF_FFFF);
        row_pred(CMD_ADD, 16'h0040, 1'b0, 32'h0000_FFFF);
        row_pred(CMD_ADD, 16'h0080, 1'b1, 32'hFFFF_0000);
        row_pred(CMD_ADD, 16'h0100, 1'b0, 32'h1234_5678);
        row_pred(CMD_ADD, 16'h0200, 1'b1, 32'h0F0F_0F0F);
        row_pred(CMD_ADD, 16'h0400, 1'b0, 32'hF0F0_F0F0);
        row_pred(CMD_ADD, 16'h0800, 1'b1, 32'h0000_0002);
        row_pred(CMD_ADD, 16'h8000, 1'b0, 32'h3333_3333);
        row_pred(CMD_ADD, 16'h7FFF, 1'b1, 32'hCCCC_CCCC);
        // New key on a full table is refused; an existing key is still updated.
        row_known(CMD_ADD,    16'h0BAD, 1'b1, 32'h0000_0003, ST_FULL, 32'h0, 32'h0);
        row_pred(CMD_ADD, 16'hFFFF, 1'b1, 32'h0000_1234);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_word(directed_rows[k].word, directed_rows[k].known, directed_rows[k].result);

        // Random traffic in phases, each with its own key pool and command mix.
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % PHASE_LEN == 0) begin
                // Hold the sender until every pending result has drained.
                in_valid <= 1'b0;
                while (results_due.size() != 0) @(posedge clk);
                case ($urandom_range(0, 3))
                    0: pool_n = 3;
                    1: pool_n = 12;
                    2: pool_n = 20;
                    default: pool_n = POOL_MAX;
                endcase
                add_pct = $urandom_range(20, 70);
                for (k = 0; k < pool_n; k++) begin
                    if (k > 0 && $urandom_range(0, 3) == 0) begin
                        pool_id[k]   = pool_id[k-1];
                        pool_proc[k] = ~pool_proc[k-1];
                    end else begin
                        pool_id[k]   = 16'($urandom_range(0, 65535));
                        pool_proc[k] = 1'($urandom_range(0, 1));
                    end
                end
                if (n < RAND_ITEMS - QUIET_TAIL)
                    idling <= ($urandom_range(0, 3) != 0);
            end
            if (n == RAND_ITEMS - QUIET_TAIL)
                idling <= 1'b0;

            // Mostly keys from the pool, sometimes an arbitrary key.
            if ($urandom_range(0, 9) == 0) begin
                w.client    = 16'($urandom_range(0, 65535));
                w.proc_flag = 1'($urandom_range(0, 1));
            end else begin
                k = $urandom_range(0, pool_n - 1);
                w.client    = pool_id[k];
                w.proc_flag = pool_proc[k];
            end
            case ($urandom_range(0, 9))
                0: w.interval = 32'h0000_0000;
                1: w.interval = 32'hFFFF_FFFF;
                2, 3, 4: w.interval = $urandom_range(0, 15);
                default: w.interval = $urandom;
            endcase
            r = $urandom_range(0, 99);
            if (r < 3)
                w.cmd = CMD_SPARE;
            else if (r < 3 + add_pct)
                w.cmd = CMD_ADD;
            else if (r % 2 == 0)
                w.cmd = CMD_DEL;
            else
                w.cmd = CMD_LOOKUP;
            send_word(w, 1'b0, '0);
        end

        // Drain, then keep watching for stray words before the verdict.
        in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
